// ----- sv/smoothstep_trajectory_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Smoothstep trajectory generator assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SMOOTHSTEP_TRAJECTORY_GENERATOR_MACROS_SVH
`define SMOOTHSTEP_TRAJECTORY_GENERATOR_MACROS_SVH

// Assert a property on the rising clock, disabled while reset is low
`define SSTG_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sstg assertion failed");

// Assert a property on the rising clock, also checked during reset
`define SSTG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sstg assertion failed");

`endif

// ----- sv/sstg_pkg.sv -----
// ----------------------------------------------------------------------------
// sstg_pkg
// Types and constants of the smoothstep trajectory generator.
// ----------------------------------------------------------------------------
package sstg_pkg;

    // Largest point count of one trajectory
    localparam logic [12:0] MAX_POINTS    = 13'd4096;
    // 1.5 times one million microseconds per second
    localparam logic [31:0] TIME_SCALE    = 32'd1500000;

    // Divider step counts: point offset and point count
    localparam int          DIV_STEP_W    = 6;
    localparam logic [5:0]  DIV_STEPS_PT  = 6'd32;
    localparam logic [5:0]  DIV_STEPS_CNT = 6'd13;
    localparam int          DIV_REM_W     = 51;

    // Opcodes
    localparam logic [1:0]  OP_START  = 2'd0;
    localparam logic [1:0]  OP_NEXT   = 2'd1;
    localparam logic [1:0]  OP_FETCH  = 2'd2;
    localparam logic [1:0]  OP_STATUS = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  REG_MAX_VEL  = 1'b0;
    localparam logic [0:0]  REG_TICK_US  = 1'b1;
    localparam int          CFG_DATA_W   = 31;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] start_position;
        logic signed [31:0] target_position;
        logic [11:0]        wanted_index;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] position;
        logic [11:0]        point_index;
        logic [12:0]        point_count;
        logic               done_res;
    } t_out_res;

    typedef struct packed {
        logic                  load;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

// ----- sv/sstg_mul.sv -----
// ----------------------------------------------------------------------------
// sstg_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sstg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    // Register the product of the operands chosen by the sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/sstg_div.sv -----
// ----------------------------------------------------------------------------
// sstg_div
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module sstg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sstg_pkg::t_div_cmd             i_cmd,
    input  logic [sstg_pkg::DIV_REM_W-1:0] i_rem_init,
    input  logic [31:0]                    i_low,
    input  logic [sstg_pkg::DIV_REM_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic [31:0]                    o_quot,
    output logic [sstg_pkg::DIV_REM_W-1:0] o_rem
);
    import sstg_pkg::*;

    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_REM_W-1:0]  r_div;
    logic [31:0]           r_low;
    logic [31:0]           r_quot;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;

    logic [DIV_REM_W:0]    w_trial;
    logic [DIV_REM_W:0]    w_diff;
    logic                  w_fit;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_trial = {r_rem, r_low[31]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Load the operands, then advance remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= i_rem_init;
            r_low  <= i_low;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
            r_low  <= {r_low[30:0], 1'b0};
            r_quot <= {r_quot[30:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- sv/smoothstep_trajectory_generator.sv -----
// ----------------------------------------------------------------------------
// smoothstep_trajectory_generator
// Smoothstep motion setpoint generator with one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: start a
//   trajectory, step to the next point, fetch a point at an index, or read
//   the status. Every request gives exactly one result on the output channel
//   (o_out_valid / i_out_stall).
//   A start request works two products and a division of 13 quotient bits;
//   a next or fetch request works six products and a division of 32
//   quotient bits; a status request works neither.
//   The multiplier and the one-bit-per-cycle divider are shared, so one
//   request is worked at a time; o_in_stall is high from acceptance until
//   the result is loaded into the output register. The next request is then
//   accepted while that result still waits to be taken.
//   If the receiver stalls, the result holds and the block waits before
//   loading the following one. The write port sets max velocity (index 0)
//   and tick period (index 1); the user must write them only while the
//   block is idle, which the block itself does not enforce.
//   Reset (synchronous, active low) restores both registers, sets the point
//   count to one and the finished flag, and empties the output register.
// ----------------------------------------------------------------------------
module smoothstep_trajectory_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sstg_pkg::t_in_req               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sstg_pkg::t_out_res              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [sstg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sstg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sstg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ST0  = 4'd1;
    localparam logic [3:0] S_ST1  = 4'd2;
    localparam logic [3:0] S_ST2  = 4'd3;
    localparam logic [3:0] S_ST3  = 4'd4;
    localparam logic [3:0] S_PT0  = 4'd5;
    localparam logic [3:0] S_PT1  = 4'd6;
    localparam logic [3:0] S_PT2  = 4'd7;
    localparam logic [3:0] S_PT3  = 4'd8;
    localparam logic [3:0] S_PT4  = 4'd9;
    localparam logic [3:0] S_PT5  = 4'd10;
    localparam logic [3:0] S_PT6  = 4'd11;
    localparam logic [3:0] S_PT7  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    // Configuration
    logic [30:0]        r_max_vel;
    logic [19:0]        r_tick_us;

    // Trajectory state
    logic signed [31:0] r_origin;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [12:0]        r_count;
    logic [11:0]        r_cur_index;
    logic [31:0]        r_last_point;
    logic               r_done;

    // Working registers
    logic [52:0]        r_num;
    logic [36:0]        r_q;
    logic [36:0]        r_d;
    logic [63:0]        r_acc;

    // Output register
    t_out_res           r_out;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_out_free;
    logic               w_push;
    logic signed [32:0] w_dist;
    logic [32:0]        w_abs;
    logic [12:0]        w_req_idx;
    logic [12:0]        w_last_idx;
    logic [12:0]        w_s;
    logic [14:0]        w_blend;
    logic [68:0]        w_full;
    logic [12:0]        w_cnt_ceil;
    logic [12:0]        w_cnt;
    logic               w_round;
    logic [32:0]        w_off;
    logic [32:0]        w_pos;

    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_prod;

    t_div_cmd             w_div_cmd;
    logic [DIV_REM_W-1:0] w_div_rem;
    logic [31:0]          w_div_low;
    logic [DIV_REM_W-1:0] w_div_den;
    logic                 w_div_busy;
    logic [31:0]          w_div_quot;
    logic [DIV_REM_W-1:0] w_div_r;

    sstg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sstg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_rem_init (w_div_rem),
        .i_low      (w_div_low),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_r)
    );

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_push     = (r_state == S_OUT) && w_out_free;

    // Distance and its magnitude for a start request
    assign w_dist = $signed({i_in_data.target_position[31], i_in_data.target_position})
                  - $signed({i_in_data.start_position[31], i_in_data.start_position});
    assign w_abs  = w_dist[32] ? (33'd0 - w_dist) : w_dist;

    // Requested index before clamping
    assign w_req_idx  = (i_in_data.opcode == OP_NEXT) ? ({1'b0, r_cur_index} + 13'd1)
                                                      : {1'b0, i_in_data.wanted_index};
    assign w_last_idx = r_count - 13'd1;

    // Point terms: s = i + 1, 3n - 2s, and the full product of distance and q
    assign w_s     = {1'b0, r_cur_index} + 13'd1;
    assign w_blend = ({2'b0, r_count} + {1'b0, r_count, 1'b0}) - {1'b0, w_s, 1'b0};
    assign w_full  = {5'b0, r_acc} + {w_prod[36:0], 32'b0};

    // Point count: ceiling of the quotient, saturated and at least one
    assign w_cnt_ceil = {1'b0, w_div_quot[11:0]} + {12'b0, (w_div_r != '0)};
    always_comb begin
        priority if (r_mag == 32'd0) begin
            w_cnt = 13'd1;
        end else if (w_div_quot[12]) begin
            w_cnt = MAX_POINTS;
        end else if (w_cnt_ceil == 13'd0) begin
            w_cnt = 13'd1;
        end else begin
            w_cnt = w_cnt_ceil;
        end
    end

    // Point value: round to nearest, then apply the sign of the distance
    assign w_round = ({w_div_r, 1'b0} >= {15'b0, r_d});
    assign w_off   = {1'b0, w_div_quot} + {32'b0, w_round};
    assign w_pos   = r_neg ? ({r_origin[31], r_origin} - w_off)
                           : ({r_origin[31], r_origin} + w_off);

    // Select multiplier operands
    always_comb begin
        unique case (r_state)
            S_ST0: begin
                w_mul_a = r_mag;
                w_mul_b = TIME_SCALE;
            end
            S_ST1: begin
                w_mul_a = {1'b0, r_max_vel};
                w_mul_b = {12'b0, r_tick_us};
            end
            S_PT0: begin
                w_mul_a = {19'b0, w_s};
                w_mul_b = {19'b0, w_s};
            end
            S_PT1: begin
                w_mul_a = {7'b0, w_prod[24:0]};
                w_mul_b = {17'b0, w_blend};
            end
            S_PT2: begin
                w_mul_a = {19'b0, r_count};
                w_mul_b = {19'b0, r_count};
            end
            S_PT3: begin
                w_mul_a = {7'b0, w_prod[24:0]};
                w_mul_b = {19'b0, r_count};
            end
            S_PT4: begin
                w_mul_a = r_mag;
                w_mul_b = r_q[31:0];
            end
            S_PT5: begin
                w_mul_a = r_mag;
                w_mul_b = {27'b0, r_q[36:32]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Load the divider for the count or the point offset
    always_comb begin
        w_div_cmd.load  = 1'b0;
        w_div_cmd.steps = DIV_STEPS_PT;
        w_div_rem       = {14'b0, w_full[68:32]};
        w_div_low       = w_full[31:0];
        w_div_den       = {14'b0, r_d};
        if (r_state == S_ST2) begin
            w_div_cmd.load  = 1'b1;
            w_div_cmd.steps = DIV_STEPS_CNT;
            w_div_rem       = {11'b0, r_num[52:13]};
            w_div_low       = {r_num[12:0], 19'b0};
            w_div_den       = w_prod[DIV_REM_W-1:0];
        end else if (r_state == S_PT6) begin
            w_div_cmd.load  = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.opcode)
                        OP_START:  n_state = S_ST0;
                        OP_NEXT:   n_state = S_PT0;
                        OP_FETCH:  n_state = S_PT0;
                        OP_STATUS: n_state = S_OUT;
                    endcase
                end
            end
            S_ST0: n_state = S_ST1;
            S_ST1: n_state = S_ST2;
            S_ST2: n_state = S_ST3;
            S_ST3: if (!w_div_busy) n_state = S_OUT;
            S_PT0: n_state = S_PT1;
            S_PT1: n_state = S_PT2;
            S_PT2: n_state = S_PT3;
            S_PT3: n_state = S_PT4;
            S_PT4: n_state = S_PT5;
            S_PT5: n_state = S_PT6;
            S_PT6: n_state = S_PT7;
            S_PT7: if (!w_div_busy) n_state = S_OUT;
            S_OUT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= 31'd65536;
            r_tick_us <= 20'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_VEL: r_max_vel <= i_cfg_data;
                REG_TICK_US: r_tick_us <= i_cfg_data[19:0];
            endcase
        end
    end

    // Update trajectory state on acceptance and at the end of the work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin     <= '0;
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_count      <= 13'd1;
            r_cur_index  <= '0;
            r_last_point <= '0;
            r_done       <= 1'b1;
        end else begin
            if (w_accept) begin
                if (i_in_data.opcode == OP_START) begin
                    r_origin <= i_in_data.start_position;
                    r_mag    <= w_abs[31:0];
                    r_neg    <= w_dist[32];
                end else if (i_in_data.opcode != OP_STATUS) begin
                    if (w_req_idx > w_last_idx) begin
                        r_cur_index <= w_last_idx[11:0];
                        r_done      <= 1'b1;
                    end else begin
                        r_cur_index <= w_req_idx[11:0];
                    end
                end
            end
            if ((r_state == S_ST3) && !w_div_busy) begin
                r_count      <= w_cnt;
                r_cur_index  <= '0;
                r_last_point <= r_origin;
                r_done       <= 1'b0;
            end
            if ((r_state == S_PT7) && !w_div_busy) begin
                r_last_point <= w_pos[31:0];
            end
        end
    end

    // Capture intermediate products
    always_ff @(posedge i_clk) begin
        if (r_state == S_ST1) begin
            r_num <= w_prod[52:0];
        end
        if (r_state == S_PT2) begin
            r_q <= w_prod[36:0];
        end
        if (r_state == S_PT4) begin
            r_d <= w_prod[36:0];
        end
        if (r_state == S_PT5) begin
            r_acc <= w_prod;
        end
    end

    // Output register: load the result, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out.position    <= r_last_point;
            r_out.point_index <= r_cur_index;
            r_out.point_count <= r_count;
            r_out.done_res    <= r_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/sstg_checker.sv -----
// ----------------------------------------------------------------------------
// sstg_port_checker
// Port-level checks of the smoothstep trajectory generator, bound to the top.
// ----------------------------------------------------------------------------
`include "smoothstep_trajectory_generator_macros.svh"

module sstg_port_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  sstg_pkg::t_out_res i_out_data
);
    import sstg_pkg::*;

    // A stalled result holds
    `SSTG_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))

    // Reset empties the output and leaves the block ready
    `SSTG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid && !i_in_stall)

    // An accepted request keeps the block busy in the next cycle
    `SSTG_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall |=> i_in_stall)

    // A new result appears only from a request in progress
    `SSTG_ASSERT_RST(a_result_from_request, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_stall))

endmodule

bind smoothstep_trajectory_generator sstg_port_checker u_sstg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ----- dv/sstg_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sstg_checker
// Watches both channels and the write port of the smoothstep trajectory
// generator. It keeps its own trajectory state, works out the result of
// every accepted request and compares each returned point field by field.
// ----------------------------------------------------------------------------
module sstg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  sstg_pkg::t_in_req               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  sstg_pkg::t_out_res              i_out_data,
    input  logic                            i_cfg_we,
    input  logic [sstg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sstg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import sstg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Register copies
    logic [30:0]        cfg_max_vel;
    logic [19:0]        cfg_tick_us;

    // Trajectory state
    logic signed [31:0] trj_origin;
    logic signed [32:0] trj_travel;
    logic [12:0]        trj_count;
    logic [11:0]        trj_index;
    logic signed [31:0] trj_point;
    logic               trj_done;

    t_out_res           awaited_points[$];
    t_out_res           want;
    int                 fail_tally;
    int                 results_seen;

    // Point idx: the origin plus the offset rounded to nearest, ties away from zero
    function automatic logic signed [31:0] smooth_point(logic [11:0] idx);
        logic [32:0]  mag;
        logic [127:0] s, n, q, d, prod, quo, rem;
        mag  = trj_travel[32] ? -trj_travel : trj_travel;
        s    = {116'b0, idx} + 128'd1;
        n    = {115'b0, trj_count};
        q    = s * s * (128'd3 * n - 128'd2 * s);
        d    = n * n * n;
        prod = {95'b0, mag} * q;
        quo  = prod / d;
        rem  = prod % d;
        if ((rem << 1) >= d) begin
            quo = quo + 128'd1;
        end
        return trj_travel[32] ? trj_origin - quo[31:0] : trj_origin + quo[31:0];
    endfunction

    // Clamp the index to the last point, flag the end, read the point
    function automatic void seek_point(logic [12:0] idx);
        if (idx > trj_count - 13'd1) begin
            idx      = trj_count - 13'd1;
            trj_done = 1'b1;
        end
        trj_index = idx[11:0];
        trj_point = smooth_point(trj_index);
    endfunction

    // Apply one request to the trajectory state and return its result
    function automatic t_out_res advance_trajectory(t_in_req r);
        logic signed [32:0] delta;
        logic [32:0]        mag;
        logic [63:0]        num, den, cnt;
        t_out_res           res;
        case (r.opcode)
            OP_START: begin
                delta = {r.target_position[31], r.target_position}
                      - {r.start_position[31], r.start_position};
                mag   = delta[32] ? -delta : delta;
                num   = {31'b0, mag} * {32'b0, TIME_SCALE};
                den   = {33'b0, cfg_max_vel} * {44'b0, cfg_tick_us};
                if (mag == 33'd0) begin
                    cnt = 64'd1;
                end else if (den == 64'd0) begin
                    cnt = {51'b0, MAX_POINTS};
                end else begin
                    cnt = num / den + ((num % den) != 64'd0 ? 64'd1 : 64'd0);
                end
                if (cnt > {51'b0, MAX_POINTS}) begin
                    cnt = {51'b0, MAX_POINTS};
                end
                trj_origin = r.start_position;
                trj_travel = delta;
                trj_count  = cnt[12:0];
                trj_index  = 12'd0;
                trj_point  = r.start_position;
                trj_done   = 1'b0;
            end
            OP_NEXT:  seek_point({1'b0, trj_index} + 13'd1);
            OP_FETCH: seek_point({1'b0, r.wanted_index});
            default: begin
                // status read leaves the state alone
            end
        endcase
        res.position    = trj_point;
        res.point_index = trj_index;
        res.point_count = trj_count;
        res.done_res    = trj_done;
        return res;
    endfunction

    // Track registers, predict on each request, compare on each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_max_vel   = 31'd65536;
            cfg_tick_us   = 20'd1000;
            trj_origin    = '0;
            trj_travel    = '0;
            trj_count     = 13'd1;
            trj_index     = '0;
            trj_point     = '0;
            trj_done      = 1'b1;
            fail_tally    = 0;
            results_seen  = 0;
            awaited_points.delete();
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAX_VEL: cfg_max_vel = i_cfg_data;
                    REG_TICK_US: cfg_tick_us = i_cfg_data[19:0];
                    default: ;
                endcase
            end

            // Compare the returned point with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_points.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= REPORT_LIMIT) begin
                        $display("result %0d with nothing pending: pos %h idx %0d cnt %0d done %0d",
                                 results_seen, i_out_data.position, i_out_data.point_index,
                                 i_out_data.point_count, i_out_data.done_res);
                    end
                end else begin
                    want = awaited_points.pop_front();
                    if (i_out_data.position !== want.position
                            || i_out_data.point_index !== want.point_index
                            || i_out_data.point_count !== want.point_count
                            || i_out_data.done_res !== want.done_res) begin
                        fail_tally++;
                        if (fail_tally <= REPORT_LIMIT) begin
                            $display("result %0d mismatch:", results_seen);
                            $display("  expected pos %h idx %0d cnt %0d done %0d",
                                     want.position, want.point_index,
                                     want.point_count, want.done_res);
                            $display("  got      pos %h idx %0d cnt %0d done %0d",
                                     i_out_data.position, i_out_data.point_index,
                                     i_out_data.point_count, i_out_data.done_res);
                        end
                    end
                end
            end

            // Queue the prediction for an accepted request
            if (i_in_valid && !i_in_stall) begin
                awaited_points = {awaited_points, advance_trajectory(i_in_data)};
            end

            o_fail_count  <= fail_tally;
            o_outstanding <= awaited_points.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the smoothstep trajectory generator. A directed
// run covers reset state, extreme distances and indexes and every opcode;
// then phases of random sequences of all opcodes run under several
// register settings, idling at random on both channels but in one phase.
// ----------------------------------------------------------------------------
module tb_top;
    import sstg_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_REQS  = 128;
    localparam int PHASES      = 10;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in_req               in_data    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out_res              out_data;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  calm       = 1'b0;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    int op_tally [4];
    int settings_used = 1;
    int sent_in_phase;
    int run_len;
    int pick;

    smoothstep_trajectory_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sstg_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Receiver: stall at random outside the calm phase
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // Watchdog: end the run when no request or result moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles, %0d results pending",
                         STALL_LIMIT, outstanding);
                $display("smoothstep_trajectory_generator verification failed");
                $finish;
            end
        end
    end

    function automatic t_in_req make_req(logic [1:0] op, logic [31:0] st, logic [31:0] tg,
                                         logic [11:0] idx);
        t_in_req r;
        r.opcode          = op;
        r.start_position  = st;
        r.target_position = tg;
        r.wanted_index    = idx;
        return r;
    endfunction

    // Start with a random origin and a span from zero up to full range
    function automatic t_in_req random_start();
        logic [31:0] st, span;
        st = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            st = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        case ($urandom_range(0, 9))
            0:       span = 32'd0;
            1, 2, 3, 4: span = $urandom_range(0, 2048);
            5, 6, 7: span = $urandom_range(0, 1 << 20);
            8:       span = $urandom_range(0, 1 << 28);
            default: span = $urandom;
        endcase
        if ($urandom_range(0, 1)) begin
            span = -span;
        end
        return make_req(OP_START, st, st + span, 12'($urandom_range(0, 4095)));
    endfunction

    // Fetch mostly early points, sometimes anywhere or near the top index
    function automatic t_in_req random_fetch();
        logic [11:0] idx;
        case ($urandom_range(0, 3))
            0, 1:    idx = 12'($urandom_range(0, 31));
            2:       idx = 12'($urandom_range(0, 4095));
            default: idx = 12'($urandom_range(4064, 4095));
        endcase
        return make_req(OP_FETCH, $urandom, $urandom, idx);
    endfunction

    // Offer one request, idling first at random, and hold it until accepted
    task automatic push_req(input t_in_req r);
        while (!calm && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        op_tally[r.opcode]++;
    endtask

    task automatic send(input logic [1:0] op, input logic [31:0] st, input logic [31:0] tg,
                        input logic [11:0] idx);
        push_req(make_req(op, st, tg, idx));
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_regs(input logic [30:0] vel, input logic [30:0] tick);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_VEL;
        cfg_data  <= vel;
        @(posedge clk);
        cfg_index <= REG_TICK_US;
        cfg_data  <= tick;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        foreach (op_tally[k]) op_tally[k] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, short and extreme trajectories, clamping
        send(OP_STATUS, 32'h0, 32'h0, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd0);
        send(OP_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send(OP_FETCH, 32'h0, 32'h0, 12'hFFF);
        send(OP_START, 32'h0, 32'h0001_0000, 12'd0);
        send(OP_NEXT, 32'h0, 32'h0, 12'd0);
        send(OP_NEXT, 32'h0, 32'h0, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd0);
        send(OP_START, 32'h0100_0000, 32'h00FF_0000, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd1);
        send(OP_FETCH, 32'h0, 32'h0, 12'd2);
        send(OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'hFFF);
        send(OP_FETCH, 32'h0, 32'h0, 12'd2048);
        send(OP_NEXT, 32'h0, 32'h0, 12'd0);
        send(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 12'hFFF);
        send(OP_FETCH, 32'h0, 32'h0, 12'hFFF);
        send(OP_NEXT, 32'h0, 32'h0, 12'd0);
        send(OP_START, 32'h1234_5678, 32'h1234_5678, 12'd0);
        send(OP_NEXT, 32'h0, 32'h0, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd7);
        send(OP_STATUS, 32'hFFFF_FFFF, 32'h0, 12'hFFF);
        send(OP_START, 32'h0, 32'h000A_0000, 12'd0);
        send(OP_FETCH, 32'h0, 32'h0, 12'd14);

        // Random phases; each one after the first begins with a register write
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                settle();
                case (phase)
                    1: write_regs(31'd65536, 31'd1000);
                    2: write_regs(31'd1, 31'd1);
                    3: write_regs(31'h7FFF_FFFF, 31'd1000000);
                    4: write_regs(31'd0, 31'd1000);
                    5: write_regs(31'd65536, 31'd0);
                    6: write_regs(31'($urandom_range(1 << 16, 1 << 24)),
                                  31'($urandom_range(1, 1000000)));
                    7: write_regs(31'd1 << 20, 31'd100);
                    8: write_regs(31'($urandom), 31'($urandom_range(0, 1000000)));
                    default: write_regs(31'd3276800, 31'd1000);
                endcase
            end
            calm <= (phase == 3);
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_REQS) begin
                if ($urandom_range(0, 4) != 0) begin
                    // well-formed: a start followed by a run of reads
                    push_req(random_start());
                    run_len = $urandom_range(1, 15);
                    for (int k = 0; k < run_len; k++) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6) begin
                            push_req(make_req(OP_NEXT, $urandom, $urandom,
                                              12'($urandom_range(0, 4095))));
                        end else if (pick < 9) begin
                            push_req(random_fetch());
                        end else begin
                            push_req(make_req(OP_STATUS, $urandom, $urandom,
                                              12'($urandom_range(0, 4095))));
                        end
                    end
                    sent_in_phase += run_len + 1;
                end else begin
                    // noise: any opcode with arbitrary fields
                    push_req(make_req(2'($urandom_range(0, 3)), $urandom, $urandom,
                                      12'($urandom_range(0, 4095))));
                    sent_in_phase++;
                end
            end
        end

        settle();
        repeat (60) @(posedge clk);

        $display("Run covered %0d requests (%0d start, %0d next, %0d fetch, %0d status)",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[OP_START], op_tally[OP_NEXT],
                 op_tally[OP_FETCH], op_tally[OP_STATUS]);
        $display("under %0d register settings, zero and full-scale values included",
                 settings_used);
        if (fail_count == 0 && outstanding == 0) begin
            $display("smoothstep_trajectory_generator verification clean");
        end else begin
            $display("%0d mismatches, %0d results never returned", fail_count, outstanding);
            $display("smoothstep_trajectory_generator verification failed");
        end
        $finish;
    end

endmodule
